FILE: rtl/core/number_theoretic_transform_assert.svh
// assertion macros used by the checker file of the transform block
// no dependencies; sampled on the rising edge, disabled while reset is low
`ifndef NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH
`define NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH

// consequent must hold in the same cycle
`define NTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define NTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ntt_pkg.sv
// shared types, constants and elaboration-time twiddle tables for the transform block
// no dependencies
package ntt_pkg;

    localparam int MAX_LOG   = 10;
    localparam int WORDS     = 1 << MAX_LOG;
    localparam int ADDR_W    = MAX_LOG;
    localparam int CNT_W     = MAX_LOG + 1;
    localparam int LOG_W     = $clog2(MAX_LOG + 1);
    localparam int WORD_W    = 30;
    localparam int TW_N      = 2 * (MAX_LOG + 1);
    localparam int TW_IDX_W  = $clog2(TW_N);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [WORD_W-1:0] PRIME = 30'd924844033;
    localparam logic [WORD_W-1:0] ROOT  = 30'd5;
    // floor(2^60 / p) for the barrett reduction
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd924844033);

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  op;
        word_t sample;
    } item_t;

    typedef struct packed {
        word_t result;
        logic  last;
    } res_t;

    typedef logic [TW_N-1:0][WORD_W-1:0]      tw_tab_t;
    typedef logic [MAX_LOG:0][WORD_W-1:0]     ninv_tab_t;

    function automatic longint unsigned const_mulmod(longint unsigned a, longint unsigned b);
        return (a * b) % 64'(PRIME);
    endfunction

    function automatic longint unsigned const_pow(longint unsigned base, longint unsigned e);
        longint unsigned acc;
        longint unsigned b;
        acc = 1;
        b   = base % 64'(PRIME);
        for (int i = 0; i < 31; i++)
        begin
            if (e[i])
                acc = const_mulmod(acc, b);
            b = const_mulmod(b, b);
        end
        return acc;
    endfunction

    // entry s: root for span 2^s; upper half holds the inverse roots
    function automatic tw_tab_t make_tw();
        tw_tab_t         tab;
        longint unsigned e;
        for (int inv = 0; inv < 2; inv++)
        begin
            for (int s = 0; s <= MAX_LOG; s++)
            begin
                e = (64'(PRIME) - 1) >> s;
                if (inv != 0)
                    e = (64'(PRIME) - 1) - e;
                tab[inv * (MAX_LOG + 1) + s] = WORD_W'(const_pow(64'(ROOT), e));
            end
        end
        return tab;
    endfunction

    function automatic ninv_tab_t make_ninv();
        ninv_tab_t tab;
        for (int l = 0; l <= MAX_LOG; l++)
            tab[l] = WORD_W'(const_pow(64'd1 << l, 64'(PRIME) - 2));
        return tab;
    endfunction

    localparam tw_tab_t   TW_TAB   = make_tw();
    localparam ninv_tab_t NINV_TAB = make_ninv();

endpackage

FILE: rtl/core/ntt_modmul.sv
// pipelined modular multiplier, barrett reduction
// depends on ntt_pkg
module ntt_modmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ntt_pkg::word_t a,
    input  ntt_pkg::word_t b,
    output logic          done,
    output ntt_pkg::word_t res
);
    import ntt_pkg::*;

    localparam logic [31:0] P1 = 32'(PRIME);
    localparam logic [31:0] P2 = 32'(PRIME) << 1;

    logic [4:0]  vld_reg;
    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] x2_reg;
    logic [31:0] qp_reg;
    logic [31:0] x3_reg;
    logic [31:0] r_reg;
    word_t       res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], start};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {30'd0, a} * {30'd0, b};
        q2_reg   <= {31'd0, prod_reg[59:29]} * {31'd0, BARRETT_MU};
        x2_reg   <= prod_reg[31:0];
        qp_reg   <= 32'({30'd0, q2_reg[61:31]} * {31'd0, PRIME});
        x3_reg   <= x2_reg;
        // remainder is below 3p, so the low 32 bits suffice
        r_reg    <= x3_reg - qp_reg;
        if (r_reg >= P2)
            res_reg <= WORD_W'(r_reg - P2);
        else if (r_reg >= P1)
            res_reg <= WORD_W'(r_reg - P1);
        else
            res_reg <= WORD_W'(r_reg);
    end

    assign done = vld_reg[4];
    assign res  = res_reg;

endmodule

FILE: rtl/core/number_theoretic_transform.sv
// Radix-2 NTT over p = 924844033 (root 5), N = 2^length_log2 residues, up to 1024.
// A load is written straight to memory; a read goes through a memory read, then the
// output register. After the N-th load the block runs log2(N) Stockham stages out of
// two 1024 x 30 dual-port memories with two five-stage modular multipliers working
// side by side (product and next twiddle): each butterfly takes two reads, a multiply
// and two writes, and the transform ends with a final pass that scales by 1/N (inverse
// mode) or copies the result back (odd log2(N)). Loads and reads are held off while
// the transform runs. Reads before completion give nothing.
// depends on ntt_pkg and ntt_modmul
module number_theoretic_transform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ntt_pkg::item_t                      item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output ntt_pkg::res_t                       res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ntt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ntt_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_READ    = 4'd1;
    localparam logic [3:0] ST_BF_RA   = 4'd2;
    localparam logic [3:0] ST_BF_RB   = 4'd3;
    localparam logic [3:0] ST_BF_MUL  = 4'd4;
    localparam logic [3:0] ST_BF_WAIT = 4'd5;
    localparam logic [3:0] ST_BF_WLO  = 4'd6;
    localparam logic [3:0] ST_BF_WHI  = 4'd7;
    localparam logic [3:0] ST_FN_RD   = 4'd8;
    localparam logic [3:0] ST_FN_MUL  = 4'd9;
    localparam logic [3:0] ST_FN_WAIT = 4'd10;

    // memories
    word_t ping_mem [WORDS];
    word_t pong_mem [WORDS];
    word_t ping_rdata_reg;
    word_t pong_rdata_reg;

    logic              ping_re, pong_re, ping_we, pong_we;
    logic [ADDR_W-1:0] ping_raddr, pong_raddr, ping_waddr, pong_waddr;
    word_t             ping_wdata, pong_wdata;

    // control
    logic [3:0]        state_reg, state_next;
    logic [LOG_W-1:0]  len_reg;
    logic              inv_cfg_reg;
    logic [LOG_W-1:0]  lg_reg, lg_next;
    logic              inv_reg, inv_next;
    logic              sel_reg, sel_next;
    logic [LOG_W-1:0]  stage_reg, stage_next;
    logic [ADDR_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0]  load_index_reg, load_index_next;
    logic [CNT_W-1:0]  read_index_reg, read_index_next;
    logic              results_reg, results_next;
    logic              rd_last_reg, rd_last_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg;

    // datapath
    word_t t_reg, t_next;
    word_t a_reg;
    word_t tb_reg;
    word_t tw_reg;

    logic [LOG_W-1:0]  eff_lg;
    logic [CNT_W-1:0]  n_cur;
    logic [CNT_W-1:0]  n_run;
    logic [ADDR_W-1:0] nh;
    logic [ADDR_W-1:0] half;
    logic [ADDR_W-1:0] k_mask;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [ADDR_W-1:0] m_inc;
    logic [TW_IDX_W-1:0] tw_idx;
    word_t             src_rdata;
    word_t             sample_red;
    logic [WORD_W:0]   sum_raw;
    word_t             sum_mod;
    word_t             diff_mod;
    logic [CNT_W-1:0]  load_pos;
    logic [CNT_W-1:0]  load_inc;
    logic              xfer_in;
    logic              rd_ok;

    logic  mm0_start, mm1_start, mm0_done, mm1_done;
    word_t mm0_a, mm0_b, mm0_res, mm1_res;

    ntt_modmul u_mm0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm0_start),
        .a     (mm0_a),
        .b     (mm0_b),
        .done  (mm0_done),
        .res   (mm0_res)
    );

    ntt_modmul u_mm1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm1_start),
        .a     (t_reg),
        .b     (TW_TAB[tw_idx]),
        .done  (mm1_done),
        .res   (mm1_res)
    );

    always_ff @(posedge clk)
    begin
        if (ping_we)
            ping_mem[ping_waddr] <= ping_wdata;
        if (ping_re)
            ping_rdata_reg <= ping_mem[ping_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pong_we)
            pong_mem[pong_waddr] <= pong_wdata;
        if (pong_re)
            pong_rdata_reg <= pong_mem[pong_raddr];
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LOG_W'(MAX_LOG);
            inv_cfg_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LENGTH_LOG2:  len_reg     <= cfg_data;
                REG_INVERSE_MODE: inv_cfg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (len_reg < LOG_W'(1))
            eff_lg = LOG_W'(1);
        else if (len_reg > LOG_W'(MAX_LOG))
            eff_lg = LOG_W'(MAX_LOG);
        else
            eff_lg = len_reg;
    end

    assign n_cur   = CNT_W'(1) << eff_lg;
    assign n_run   = CNT_W'(1) << lg_reg;
    assign nh      = ADDR_W'(n_run >> 1);
    assign half    = ADDR_W'(1) << (stage_reg - LOG_W'(1));
    assign k_mask  = half - ADDR_W'(1);
    assign lo_addr = (m_reg << 1) - (m_reg & k_mask);
    assign hi_addr = lo_addr + half;
    assign m_inc   = m_reg + ADDR_W'(1);
    assign tw_idx  = TW_IDX_W'(stage_reg) + (inv_reg ? TW_IDX_W'(MAX_LOG + 1) : TW_IDX_W'(0));

    assign src_rdata  = sel_reg ? pong_rdata_reg : ping_rdata_reg;
    assign sample_red = (item.sample >= PRIME) ? item.sample - PRIME : item.sample;

    assign sum_raw  = {1'b0, a_reg} + {1'b0, tb_reg};
    assign sum_mod  = (sum_raw >= {1'b0, PRIME}) ? WORD_W'(sum_raw - {1'b0, PRIME})
                                                 : WORD_W'(sum_raw);
    assign diff_mod = (a_reg >= tb_reg) ? a_reg - tb_reg
                                        : WORD_W'({1'b0, a_reg} + {1'b0, PRIME} - {1'b0, tb_reg});

    assign load_pos = results_reg ? '0 : load_index_reg;
    assign load_inc = load_pos + CNT_W'(1);

    assign item_ready = (state_reg == ST_IDLE);
    assign xfer_in    = item_valid && item_ready;
    assign rd_ok      = !out_valid_reg || res_ready;

    assign mm0_start = (state_reg == ST_BF_MUL) || (state_reg == ST_FN_MUL);
    assign mm1_start = (state_reg == ST_BF_MUL);
    assign mm0_a     = (state_reg == ST_FN_MUL) ? src_rdata : t_reg;
    assign mm0_b     = (state_reg == ST_FN_MUL) ? (inv_reg ? NINV_TAB[lg_reg] : word_t'(1))
                                                : src_rdata;

    // memory port steering
    always_comb
    begin
        ping_re    = 1'b0;
        pong_re    = 1'b0;
        ping_we    = 1'b0;
        pong_we    = 1'b0;
        ping_raddr = m_reg;
        pong_raddr = m_reg;
        ping_waddr = lo_addr;
        pong_waddr = lo_addr;
        ping_wdata = sum_mod;
        pong_wdata = sum_mod;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (xfer_in && item.op == OP_LOAD)
                begin
                    ping_we    = 1'b1;
                    ping_waddr = ADDR_W'(load_pos);
                    ping_wdata = sample_red;
                end
                else if (xfer_in && results_reg)
                begin
                    ping_re    = 1'b1;
                    ping_raddr = ADDR_W'(read_index_reg);
                end
            end
            ST_BF_RA, ST_FN_RD:
            begin
                ping_re = !sel_reg;
                pong_re = sel_reg;
            end
            ST_BF_RB:
            begin
                ping_re    = !sel_reg;
                pong_re    = sel_reg;
                ping_raddr = m_reg + nh;
                pong_raddr = m_reg + nh;
            end
            ST_BF_WLO:
            begin
                ping_we = sel_reg;
                pong_we = !sel_reg;
            end
            ST_BF_WHI:
            begin
                ping_we    = sel_reg;
                pong_we    = !sel_reg;
                ping_waddr = hi_addr;
                pong_waddr = hi_addr;
                ping_wdata = diff_mod;
                pong_wdata = diff_mod;
            end
            ST_FN_WAIT:
            begin
                ping_we    = mm0_done;
                ping_waddr = m_reg;
                ping_wdata = mm0_res;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        lg_next         = lg_reg;
        inv_next        = inv_reg;
        sel_next        = sel_reg;
        stage_next      = stage_reg;
        m_next          = m_reg;
        t_next          = t_reg;
        load_index_next = load_index_reg;
        read_index_next = read_index_reg;
        results_next    = results_reg;
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (xfer_in && item.op == OP_LOAD)
                begin
                    results_next    = 1'b0;
                    read_index_next = '0;
                    if (load_inc >= n_cur)
                    begin
                        load_index_next = '0;
                        lg_next         = eff_lg;
                        inv_next        = inv_cfg_reg;
                        sel_next        = 1'b0;
                        stage_next      = LOG_W'(1);
                        m_next          = '0;
                        t_next          = word_t'(1);
                        state_next      = ST_BF_RA;
                    end
                    else
                        load_index_next = load_inc;
                end
                else if (xfer_in && results_reg)
                begin
                    state_next = ST_READ;
                    if (read_index_reg >= n_cur - CNT_W'(1))
                    begin
                        rd_last_next    = 1'b1;
                        results_next    = 1'b0;
                        read_index_next = '0;
                        load_index_next = '0;
                    end
                    else
                    begin
                        rd_last_next    = 1'b0;
                        read_index_next = read_index_reg + CNT_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                if (rd_ok)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_BF_RA:   state_next = ST_BF_RB;
            ST_BF_RB:   state_next = ST_BF_MUL;
            ST_BF_MUL:  state_next = ST_BF_WAIT;
            ST_BF_WAIT:
            begin
                if (mm0_done)
                    state_next = ST_BF_WLO;
            end
            ST_BF_WLO:  state_next = ST_BF_WHI;
            ST_BF_WHI:
            begin
                // twiddle restarts at one at each group boundary
                t_next = ((m_inc & k_mask) == '0) ? word_t'(1) : tw_reg;
                if (m_reg != nh - ADDR_W'(1))
                begin
                    m_next     = m_inc;
                    state_next = ST_BF_RA;
                end
                else
                begin
                    m_next   = '0;
                    t_next   = word_t'(1);
                    sel_next = !sel_reg;
                    if (stage_reg != lg_reg)
                    begin
                        stage_next = stage_reg + LOG_W'(1);
                        state_next = ST_BF_RA;
                    end
                    else if (!sel_reg || inv_reg)
                        state_next = ST_FN_RD;
                    else
                    begin
                        results_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_FN_RD:   state_next = ST_FN_MUL;
            ST_FN_MUL:  state_next = ST_FN_WAIT;
            ST_FN_WAIT:
            begin
                if (mm0_done)
                begin
                    if ({1'b0, m_reg} == n_run - CNT_W'(1))
                    begin
                        m_next       = '0;
                        results_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        m_next     = m_inc;
                        state_next = ST_FN_RD;
                    end
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lg_reg         <= LOG_W'(1);
            inv_reg        <= 1'b0;
            sel_reg        <= 1'b0;
            stage_reg      <= LOG_W'(1);
            m_reg          <= '0;
            load_index_reg <= '0;
            read_index_reg <= '0;
            results_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lg_reg         <= lg_next;
            inv_reg        <= inv_next;
            sel_reg        <= sel_next;
            stage_reg      <= stage_next;
            m_reg          <= m_next;
            load_index_reg <= load_index_next;
            read_index_reg <= read_index_next;
            results_reg    <= results_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (state_reg == ST_BF_RB)
            a_reg <= src_rdata;
        if (state_reg == ST_BF_WAIT && mm0_done)
            tb_reg <= mm0_res;
        if (mm1_done)
            tw_reg <= mm1_res;
        if (state_reg == ST_READ && rd_ok)
            out_data_reg <= '{result: ping_rdata_reg, last: rd_last_reg};
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule

FILE: rtl/core/ntt_checker.sv
// port-level checks for the transform block, bound onto the top level
// depends on ntt_pkg and the assertion macro header
`include "number_theoretic_transform_assert.svh"

module ntt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_ready,
    input logic           res_valid,
    input logic           res_ready,
    input ntt_pkg::res_t  res
);
    import ntt_pkg::*;

    // a waiting result holds until its transfer
    `NTT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

    // every result is a reduced residue
    `NTT_ASSERT_NOW(a_res_range, clk, rst_n, res_valid, res.result < PRIME, "result not below the prime")

    // a new result only follows a cycle in which the input side was held off
    `NTT_ASSERT_NOW(a_res_after_read, clk, rst_n, $rose(res_valid), !$past(item_ready), "result without a read transfer")

endmodule

bind number_theoretic_transform ntt_checker u_ntt_checker (.*);
